[hdl/deq_pkg.sv]
// Shared types, constants and ring index helpers for the double-ended queue.
// Used by deq_ctrl, deq_datapath and double_ended_queue.
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_SEARCH     = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_SEARCH,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic cap_read;
        logic load_out;
    } deq_cmd_t;

    typedef struct packed {
        logic in_pop_ok;
        logic in_search;
        logic scan_hit;
        logic scan_done;
        logic out_free;
    } deq_stat_t;

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

endpackage

[hdl/deq_ctrl.sv]
// Request sequencer for the double-ended queue.
// Depends on deq_pkg; drives deq_datapath through deq_cmd_t.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  deq_stat_t stat,
    output deq_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.in_pop_ok)
                    begin
                        state_next = S_POP_WAIT;
                    end
                    else if (stat.in_search)
                    begin
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_POP_WAIT:
            begin
                cmd.cap_read = 1'b1;
                state_next   = S_FINISH;
            end
            S_SEARCH:
            begin
                if (stat.scan_hit)
                begin
                    cmd.cap_read = 1'b1;
                    state_next   = S_FINISH;
                end
                else if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP_WAIT) |=> (state_reg == S_FINISH))
        else $error("pop read not followed by finish");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !cmd.load_out && !cmd.scan_step)
        else $error("accept overlaps other work");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && stat.out_free) |=> (state_reg == S_IDLE))
        else $error("finished result not handed off");

endmodule

[hdl/deq_datapath.sv]
// Ring store, head/tail/count registers, search scan and result registers.
// Depends on deq_pkg; commanded by deq_ctrl.
module deq_datapath
    import deq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [FUNC_W-1:0]     func,
    input  logic [VALUE_W-1:0]    data_value,
    input  deq_cmd_t              cmd,
    output deq_stat_t             stat,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [VALUE_W-1:0]    result_value,
    output logic                  found,
    output logic [STATUS_W-1:0]   status,
    output logic [COUNT_W-1:0]    count
);

    logic [DATA_WIDTH-1:0] ring_mem [DEPTH];

    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      scan_pos_reg, scan_pos_next;
    logic [CNT_W-1:0]      scan_left_reg, scan_left_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic                  out_valid_reg, out_valid_next;

    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [DATA_WIDTH-1:0] res_value_reg, res_value_next;
    logic                  found_reg, found_next;
    status_t               status_reg, status_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [VALUE_W-1:0]    out_value_reg;
    logic                  out_found_reg;
    status_t               out_status_reg;
    logic [COUNT_W-1:0]    out_count_reg;

    op_t                   op;
    logic [DATA_WIDTH-1:0] in_key;
    logic                  full;
    logic                  empty;
    logic                  is_pop;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;

    assign op     = op_t'(func);
    assign in_key = data_value[DATA_WIDTH-1:0];
    assign full   = (count_reg == FULL_CNT);
    assign empty  = (count_reg == '0);
    assign is_pop = (op == OP_POP_FRONT) || (op == OP_POP_REAR);

    assign stat.in_pop_ok = is_pop && !empty;
    assign stat.in_search = (op == OP_SEARCH);
    assign stat.scan_hit  = cmp_valid_reg && (rd_data_reg == key_reg);
    assign stat.scan_done = (scan_left_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        scan_pos_next  = scan_pos_reg;
        scan_left_next = scan_left_reg;
        key_next       = key_reg;
        res_value_next = res_value_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_pos_reg;
        cmp_valid_next = cmd.scan_step;

        if (cmd.accept)
        begin
            key_next       = in_key;
            res_value_next = '0;
            found_next     = 1'b0;
            status_next    = ST_OK;
            scan_pos_next  = head_reg;
            scan_left_next = count_reg;
            case (op)
                OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        head_next  = step_down(head_reg);
                        wr_en      = 1'b1;
                        wr_addr    = step_down(head_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_PUSH_REAR:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = tail_reg;
                        tail_next  = step_up(tail_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = head_reg;
                        head_next  = step_up(head_reg);
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_POP_REAR:
                begin
                    if (empty)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = step_down(tail_reg);
                        tail_next  = step_down(tail_reg);
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.scan_step)
        begin
            rd_en          = 1'b1;
            rd_addr        = scan_pos_reg;
            scan_pos_next  = step_up(scan_pos_reg);
            scan_left_next = scan_left_reg - 1'b1;
        end

        if (cmd.cap_read)
        begin
            res_value_next = rd_data_reg;
            found_next     = 1'b1;
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= key_next;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_pos_reg  <= '0;
            scan_left_reg <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            scan_pos_reg  <= scan_pos_next;
            scan_left_reg <= scan_left_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        res_value_reg <= res_value_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
        if (cmd.load_out)
        begin
            out_value_reg  <= VALUE_W'(res_value_reg);
            out_found_reg  <= found_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_W'(count_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign found        = out_found_reg;
    assign status       = out_status_reg;
    assign count        = out_count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result register overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && stat.in_pop_ok) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not decrement count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && full && (op == OP_PUSH_FRONT || op == OP_PUSH_REAR))
        |=> $stable(count_reg) && $stable(head_reg) && $stable(tail_reg))
        else $error("push on full queue changed state");

endmodule

[hdl/double_ended_queue.sv]
// Double-ended queue top level: stream ports, sequencer and datapath.
// Push, underflow, overflow and unused codes go from accept to the finish state; pops pass a store read state first.
// Search scans from the front until a hit or until all stored entries are checked, then finishes.
// One request in flight; the next is taken while the previous result waits at the output.
// Asynchronous active-low reset empties the queue; store contents are left as they were.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] data_value
    input  logic [FUNC_W-1:0]      s_axis_tuser,   // [2:0] func
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] result_value, [36:32] count
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // [0] found, [2:1] status
);

    deq_cmd_t              cmd;
    deq_stat_t             stat;
    logic [VALUE_W-1:0]    result_value;
    logic                  found;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    count;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    deq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .func         (s_axis_tuser),
        .data_value   (s_axis_tdata),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .result_value (result_value),
        .found        (found),
        .status       (status),
        .count        (count)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - VALUE_W - COUNT_W){1'b0}}, count, result_value};
    assign m_axis_tuser = {status, found};

endmodule

[bench/tb_double_ended_queue.sv]
// Self-checking bench for double_ended_queue: directed table, then push/pop/search phases.
// Results are predicted by a shadow deque (typed directed rows use the table) and checked beat by beat in order.
// Depends on deq_pkg and the double_ended_queue RTL.
`timescale 1ns / 100ps

module tb_double_ended_queue;
    import deq_pkg::*;

    localparam logic [FUNC_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [FUNC_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [FUNC_W-1:0] OP_SPARE_C = 3'd7;

    localparam int N_RANDOM   = 500;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_OFF   = 400;
    localparam int HOLD_AT    = 150;
    localparam int DRAIN_WAIT = 40;
    localparam int MAX_SHOWN  = 10;

    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIX   = 2;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               hit;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } deq_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   code;
        logic [VALUE_W-1:0]  value;
        logic                typed;
        logic [VALUE_W-1:0]  exp_value;
        logic                exp_hit;
        logic [STATUS_W-1:0] exp_status;
        logic [COUNT_W-1:0]  exp_count;
    } dir_row_t;

    localparam int N_DIRECTED = 23;
    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0, 1'b0, ST_UNDERFLOW, 5'd0},
        '{OP_POP_REAR,   32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, ST_UNDERFLOW, 5'd0},
        '{OP_SEARCH,     32'h0000_0000, 1'b1, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_SPARE_A,    32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_SPARE_B,    32'h0000_0000, 1'b1, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_SPARE_C,    32'hA5A5_A5A5, 1'b1, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, ST_OK,        5'd1},
        '{OP_PUSH_REAR,  32'h0000_0000, 1'b1, 32'h0, 1'b0, ST_OK,        5'd2},
        '{OP_PUSH_FRONT, 32'h8000_0000, 1'b0, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_PUSH_REAR,  32'h0000_0001, 1'b0, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_SEARCH,     32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_SEARCH,     32'h0000_0000, 1'b0, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_SEARCH,     32'h0000_0001, 1'b0, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_SEARCH,     32'h1234_5678, 1'b0, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_POP_REAR,   32'h0000_0000, 1'b1, 32'h0, 1'b0, ST_UNDERFLOW, 5'd0},
        '{OP_PUSH_REAR,  32'h5A5A_5A5A, 1'b1, 32'h0, 1'b0, ST_OK,        5'd1},
        '{OP_PUSH_REAR,  32'h5A5A_5A5A, 1'b1, 32'h0, 1'b0, ST_OK,        5'd2},
        '{OP_SEARCH,     32'h5A5A_5A5A, 1'b0, 32'h0, 1'b0, ST_OK,        5'd0},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, 1'b0, ST_OK,        5'd0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [FUNC_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    double_ended_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // shadow deque
    logic [VALUE_W-1:0] shadow_slot [DEPTH];
    int unsigned        front_ptr;
    int unsigned        rear_ptr;
    int unsigned        stored_cnt;

    deq_result_t pending_results [$];
    int unsigned fault_count;
    int unsigned results_seen;
    int unsigned burst_left;
    int unsigned idle_cycles;
    logic [VALUE_W-1:0] corner_pool [8];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic deq_result_t deque_answer(input logic [FUNC_W-1:0] code,
                                                 input logic [VALUE_W-1:0] v);
        deq_result_t r;
        int unsigned pos;
        int unsigned k;
        r.value  = '0;
        r.hit    = 1'b0;
        r.status = ST_OK;
        case (code)
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (stored_cnt >= DEPTH)
                    r.status = ST_OVERFLOW;
                else if (code == OP_PUSH_FRONT)
                begin
                    front_ptr = (front_ptr + DEPTH - 1) % DEPTH;
                    shadow_slot[front_ptr] = v;
                    stored_cnt++;
                end
                else
                begin
                    shadow_slot[rear_ptr] = v;
                    rear_ptr = (rear_ptr + 1) % DEPTH;
                    stored_cnt++;
                end
            end
            OP_POP_FRONT, OP_POP_REAR:
            begin
                if (stored_cnt == 0)
                    r.status = ST_UNDERFLOW;
                else if (code == OP_POP_FRONT)
                begin
                    r.value = shadow_slot[front_ptr];
                    r.hit = 1'b1;
                    front_ptr = (front_ptr + 1) % DEPTH;
                    stored_cnt--;
                end
                else
                begin
                    rear_ptr = (rear_ptr + DEPTH - 1) % DEPTH;
                    r.value = shadow_slot[rear_ptr];
                    r.hit = 1'b1;
                    stored_cnt--;
                end
            end
            OP_SEARCH:
            begin
                pos = front_ptr;
                for (k = 0; k < stored_cnt; k++)
                begin
                    if (!r.hit && shadow_slot[pos] == v)
                    begin
                        r.value = v;
                        r.hit = 1'b1;
                    end
                    pos = (pos + 1) % DEPTH;
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(stored_cnt);
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] fresh_value();
        if ($urandom_range(0, 99) < 30)
            return corner_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // mostly keys that are stored, so searches hit at every depth
    function automatic logic [VALUE_W-1:0] pick_key();
        if (stored_cnt != 0 && $urandom_range(0, 99) < 70)
            return shadow_slot[(front_ptr + $urandom_range(0, stored_cnt - 1)) % DEPTH];
        return fresh_value();
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic offer(input logic [FUNC_W-1:0] code, input logic [VALUE_W-1:0] v,
                         input bit typed, input deq_result_t typed_res);
        deq_result_t r;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= code;
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = deque_answer(code, v);
        pending_results.push_back(typed ? typed_res : r);
        @(negedge clk);
    endtask

    task automatic offer_checked(input logic [FUNC_W-1:0] code, input logic [VALUE_W-1:0] v);
        deq_result_t none;
        none = '0;
        offer(code, v, 1'b0, none);
    endtask

    // stimulus
    initial
    begin
        deq_result_t typed_res;
        int unsigned done_items;
        int unsigned phase_no;
        int unsigned phase_kind;
        int unsigned extra;
        int unsigned r;
        int unsigned i;
        logic [FUNC_W-1:0] code;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        fault_count   = 0;
        results_seen  = 0;
        burst_left    = 0;
        front_ptr     = 0;
        rear_ptr      = 0;
        stored_cnt    = 0;
        corner_pool   = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                          $urandom(), $urandom(), $urandom(), $urandom()};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < N_DIRECTED; i++)
        begin
            typed_res.value  = DIRECTED_ROWS[i].exp_value;
            typed_res.hit    = DIRECTED_ROWS[i].exp_hit;
            typed_res.status = status_t'(DIRECTED_ROWS[i].exp_status);
            typed_res.count  = DIRECTED_ROWS[i].exp_count;
            offer(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].value,
                  DIRECTED_ROWS[i].typed, typed_res);
        end

        done_items = 0;
        phase_no   = 0;
        while (done_items < N_RANDOM)
        begin
            if (phase_no == 0)
                phase_kind = PH_FILL;
            else if (phase_no == 2)
                phase_kind = PH_DRAIN;
            else
                phase_kind = $urandom_range(PH_FILL, PH_MIX);
            phase_no++;

            case (phase_kind)
                PH_FILL:
                begin
                    // fill to the brim, then a few pushes that must overflow
                    extra = $urandom_range(1, 4);
                    while (stored_cnt < DEPTH || extra != 0)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            offer_checked(OP_SEARCH, pick_key());
                        else
                        begin
                            if (stored_cnt == DEPTH)
                                extra--;
                            code = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
                            offer_checked(code, fresh_value());
                        end
                        done_items++;
                    end
                end
                PH_DRAIN:
                begin
                    extra = $urandom_range(1, 3);
                    while (stored_cnt != 0 || extra != 0)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            offer_checked(OP_SEARCH, pick_key());
                        else
                        begin
                            if (stored_cnt == 0)
                                extra--;
                            code = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
                            offer_checked(code, fresh_value());
                        end
                        done_items++;
                    end
                end
                default:
                begin
                    repeat ($urandom_range(20, 60))
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 3)
                        begin
                            case ($urandom_range(0, 2))
                                0:       code = OP_SPARE_A;
                                1:       code = OP_SPARE_B;
                                default: code = OP_SPARE_C;
                            endcase
                            offer_checked(code, fresh_value());
                        end
                        else
                        begin
                            if (r < 35)
                                code = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
                            else if (r < 70)
                                code = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
                            else
                                code = OP_SEARCH;
                            offer_checked(code, (code == OP_SEARCH) ? pick_key()
                                                                    : fresh_value());
                            done_items++;
                        end
                    end
                end
            endcase
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fault_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver: stall modes that change every so often, plus one long hold-off
    initial
    begin
        int unsigned mode;
        int unsigned mode_left;
        bit          held_off;
        m_axis_tready = 1'b0;
        mode_left     = 0;
        mode          = 0;
        held_off      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && results_seen >= HOLD_AT)
            begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 100);
            end
            mode_left--;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin : result_check
        deq_result_t want;
        logic [VALUE_W-1:0]  got_value;
        logic [COUNT_W-1:0]  got_count;
        logic                got_hit;
        logic [STATUS_W-1:0] got_status;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            got_value  = m_axis_tdata[VALUE_W-1:0];
            got_count  = m_axis_tdata[VALUE_W +: COUNT_W];
            got_hit    = m_axis_tuser[0];
            got_status = m_axis_tuser[1 +: STATUS_W];
            if (pending_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_SHOWN)
                    $display("%0t: unexpected result beat value %h count %0d",
                             $realtime, got_value, got_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got_value !== want.value || got_hit !== want.hit ||
                    got_status !== want.status || got_count !== want.count)
                begin
                    fault_count++;
                    if (fault_count <= MAX_SHOWN)
                        $display("%0t: beat %0d exp %h/%b/%0d/%0d got %h/%b/%0d/%0d",
                                 $realtime, results_seen, want.value, want.hit,
                                 want.status, want.count, got_value, got_hit,
                                 got_status, got_count);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
